// ===== hdl/rlfe_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlfe_pkg: shared types and constants of the RGB LED fade engine
// Widths, command and mode codes, and the divider request/response bundles.
// ---------------------------------------------------------------------------
package rlfe_pkg;

  // Field widths
  localparam int COLOR_BITS   = 8;
  localparam int TIME_BITS    = 32;
  localparam int LEN_BITS     = 16;
  localparam int PROD_BITS    = COLOR_BITS + LEN_BITS;
  localparam int DIV_STEPS    = PROD_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  typedef logic [COLOR_BITS-1:0] color_t;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_EASE  = 2'd2,
    CMD_PULSE = 2'd3
  } cmd_e;

  // Animation mode
  typedef enum logic [1:0] {
    MODE_STEADY = 2'd0,
    MODE_EASE   = 2'd1,
    MODE_PULSE  = 2'd2
  } mode_e;

  // Divider request: start pulse with operands
  typedef struct packed {
    logic                 start;
    logic [PROD_BITS-1:0] dividend;
    logic [LEN_BITS-1:0]  divisor;
  } div_req_t;

  // Divider response: done pulse with results
  typedef struct packed {
    logic                 done;
    logic [PROD_BITS-1:0] quot;
    logic [LEN_BITS-1:0]  rem;
  } div_rsp_t;

endpackage

// ===== hdl/rgb_led_fade_engine_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_led_fade_engine_top: RGB LED linear ease and pulse animator
// Keeps base and target colors and turns tick items into duty triples.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command item with a
//   millisecond timestamp. Set, ease and pulse items update state and give no
//   result. Each tick item gives one result item on the output channel
//   (out_valid_o / out_stall_i): three duties and the mode after the update.
//   A tick that finds the block steady or the animation finished goes
//   straight to the final step, which loads the output register.
//   A tick inside an animation runs the three channels one after another
//   through one multiplier and one shared bit-serial divider (per channel:
//   multiply, divider load, 24 divide steps, pick up the quotient).
//   in_stall_o is high while a tick is being worked on; one item at a time.
//   The result sits in an output register; the next item is taken while it
//   waits. If the receiver stalls, the next tick's result waits in its final
//   step and the input stays stalled until the register frees up.
//   Reset clears colors, start time, length and mode (steady, black).
// ---------------------------------------------------------------------------
module rgb_led_fade_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  input  logic [15:0] fade_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_duty_o,
  output logic [7:0]  green_duty_o,
  output logic [7:0]  blue_duty_o,
  output logic [1:0]  anim_mode_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                            state_q, state_d;
  rlfe_pkg::color_t                  base_q   [3];
  rlfe_pkg::color_t                  base_d   [3];
  rlfe_pkg::color_t                  target_q [3];
  rlfe_pkg::color_t                  target_d [3];
  rlfe_pkg::color_t                  shown_q  [3];
  rlfe_pkg::color_t                  shown_d  [3];
  rlfe_pkg::color_t                  duty_q   [3];
  rlfe_pkg::color_t                  duty_d   [3];
  logic [rlfe_pkg::TIME_BITS-1:0]    start_q, start_d;
  logic [rlfe_pkg::LEN_BITS-1:0]     len_q, len_d;
  logic [rlfe_pkg::LEN_BITS-1:0]     num_q, num_d;
  rlfe_pkg::mode_e                   mode_q, mode_d;
  logic [1:0]                        ch_q, ch_d;
  logic                              out_valid_q, out_valid_d;
  logic [1:0]                        mode_out_q, mode_out_d;
  rlfe_pkg::div_req_t                div_req_q, div_req_d;
  rlfe_pkg::div_rsp_t                div_rsp;

  rlfe_pkg::color_t                  col_in [3];
  logic [rlfe_pkg::TIME_BITS-1:0]    elapsed;
  logic                              finished;
  logic                              out_free;
  rlfe_pkg::color_t                  b_sel, t_sel, mag, adj;
  logic                              neg;

  assign col_in[0] = red_in_i;
  assign col_in[1] = green_in_i;
  assign col_in[2] = blue_in_i;

  // Shared divider
  rlfe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // Time since animation start and channel operands
  assign elapsed  = now_ms_i - start_q;
  assign finished = (elapsed >= rlfe_pkg::TIME_BITS'(len_q));
  assign out_free = !out_valid_q || !out_stall_i;
  assign b_sel    = base_q[ch_q];
  assign t_sel    = target_q[ch_q];
  assign neg      = (t_sel < b_sel);
  assign mag      = neg ? (b_sel - t_sel) : (t_sel - b_sel);
  // Negative step rounds toward minus infinity: ceil of magnitude
  assign adj      = div_rsp.quot[rlfe_pkg::COLOR_BITS-1:0]
                    + rlfe_pkg::COLOR_BITS'(div_rsp.rem != '0);

  // Sequencer and state update
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    target_d    = target_q;
    shown_d     = shown_q;
    duty_d      = duty_q;
    start_d     = start_q;
    len_d       = len_q;
    num_d       = num_q;
    mode_d      = mode_q;
    ch_d        = ch_q;
    mode_out_d  = mode_out_q;
    div_req_d   = div_req_q;
    div_req_d.start = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (rlfe_pkg::cmd_e'(cmd_i))
            rlfe_pkg::CMD_SET: begin
              base_d = col_in;
              mode_d = rlfe_pkg::MODE_STEADY;
            end
            rlfe_pkg::CMD_EASE, rlfe_pkg::CMD_PULSE: begin
              if (mode_q == rlfe_pkg::MODE_EASE) begin
                base_d = target_q;
              end
              target_d = col_in;
              mode_d   = (cmd_i == rlfe_pkg::CMD_EASE) ? rlfe_pkg::MODE_EASE
                                                       : rlfe_pkg::MODE_PULSE;
              start_d  = now_ms_i;
              len_d    = fade_ms_i;
            end
            default: begin
              // tick
              ch_d = '0;
              case (mode_q)
                rlfe_pkg::MODE_EASE: begin
                  if (finished) begin
                    base_d  = target_q;
                    shown_d = target_q;
                    mode_d  = rlfe_pkg::MODE_STEADY;
                    state_d = ST_FIN;
                  end else begin
                    num_d   = elapsed[rlfe_pkg::LEN_BITS-1:0];
                    state_d = ST_MUL;
                  end
                end
                rlfe_pkg::MODE_PULSE: begin
                  if (finished) begin
                    shown_d = base_q;
                    mode_d  = rlfe_pkg::MODE_STEADY;
                    state_d = ST_FIN;
                  end else begin
                    num_d   = len_q - elapsed[rlfe_pkg::LEN_BITS-1:0];
                    state_d = ST_MUL;
                  end
                end
                default: begin
                  shown_d = base_q;
                  mode_d  = rlfe_pkg::MODE_STEADY;
                  state_d = ST_FIN;
                end
              endcase
            end
          endcase
        end
      end
      ST_MUL: begin
        // |diff| * num, then kick off the divide by the fade length
        div_req_d.start    = 1'b1;
        div_req_d.dividend = rlfe_pkg::PROD_BITS'(mag) * rlfe_pkg::PROD_BITS'(num_q);
        div_req_d.divisor  = len_q;
        state_d            = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          shown_d[ch_q] = neg ? (b_sel - adj)
                              : (b_sel + div_rsp.quot[rlfe_pkg::COLOR_BITS-1:0]);
          if (ch_q == 2'd2) begin
            state_d = ST_FIN;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = ST_MUL;
          end
        end
      end
      ST_FIN: begin
        // Load output register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          duty_d      = shown_q;
          mode_out_d  = mode_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '{default: '0};
      target_q    <= '{default: '0};
      shown_q     <= '{default: '0};
      duty_q      <= '{default: '0};
      start_q     <= '0;
      len_q       <= '0;
      num_q       <= '0;
      mode_q      <= rlfe_pkg::MODE_STEADY;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      mode_out_q  <= '0;
      div_req_q   <= '0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      target_q    <= target_d;
      shown_q     <= shown_d;
      duty_q      <= duty_d;
      start_q     <= start_d;
      len_q       <= len_d;
      num_q       <= num_d;
      mode_q      <= mode_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      mode_out_q  <= mode_out_d;
      div_req_q   <= div_req_d;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign red_duty_o   = duty_q[0];
  assign green_duty_o = duty_q[1];
  assign blue_duty_o  = duty_q[2];
  assign anim_mode_o  = mode_out_q;

endmodule

// ===== hdl/rlfe_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlfe_div: shared restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ---------------------------------------------------------------------------
module rlfe_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rlfe_pkg::div_req_t req_i,
  output rlfe_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [rlfe_pkg::DIV_CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [rlfe_pkg::PROD_BITS-1:0]      quo_q, quo_d;
  logic [rlfe_pkg::LEN_BITS-1:0]       rem_q, rem_d;
  logic [rlfe_pkg::LEN_BITS-1:0]       dsr_q, dsr_d;
  logic [rlfe_pkg::LEN_BITS:0]         partial;
  logic [rlfe_pkg::LEN_BITS:0]         diff;
  logic                                ge;

  // One restoring step: shift in next dividend bit, try subtract
  assign partial = {rem_q, quo_q[rlfe_pkg::PROD_BITS-1]};
  assign diff    = partial - {1'b0, dsr_q};
  assign ge      = (partial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[rlfe_pkg::LEN_BITS-1:0] : partial[rlfe_pkg::LEN_BITS-1:0];
      quo_d = {quo_q[rlfe_pkg::PROD_BITS-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == rlfe_pkg::DIV_CNT_BITS'(rlfe_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dsr_q  <= dsr_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
